// File: src/difc_pkg.sv
// Shared types and constants for the display idle fade controller.
package difc_pkg;

  // Word and digit geometry of the digit-serial datapath.
  localparam int WORD_W      = 32;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = WORD_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int LEVEL_W  = 8;
  localparam int SHORT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = LEVEL_W + SHORT_W;

  // Multiply and divide both take one step per quotient or multiplier bit.
  localparam int MD_STEPS = LEVEL_W;
  localparam int MD_CNT_W = $clog2(MD_STEPS);

  localparam logic [WORD_W-1:0]  FAST_TIMEOUT_MS = WORD_W'(30 * 1000);
  localparam logic [LEVEL_W-1:0] BRIGHT_MAX      = LEVEL_W'(255);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACTIVITY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAKE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAST     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INIT     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_CHG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USER_BRIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK     = 3'd6;

  typedef enum logic [1:0] {
    MODE_AWAKE    = 2'd0,
    MODE_FADE_OUT = 2'd1,
    MODE_ASLEEP   = 2'd2,
    MODE_FADE_IN  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_CMP,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

endpackage

// File: src/display_idle_fade_controller.sv
// Top level of the display idle fade controller: sequencer, state and result register.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid / in_ready    | kind, now_ms, usb_power, enable
//   out     | output    | out_valid / out_ready  | brightness_write, brightness,
//           |           |                        | wake_consumed, asleep, mode
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick walks the timestamps through the compare lanes in eight 4-bit digit
// steps, and a fade step that needs the interpolated level adds the eight
// multiply plus eight divide steps of the interpolation unit; every other kind
// goes straight to the result. Reset is synchronous and active low and leaves
// the block idle with its control, configuration and result-valid registers
// at their reset values. A held result does not block the input at once: the
// next item is taken while the result register waits on out_ready, and the
// sequencer only stalls when a second result is ready before the first has
// gone. Configuration writes are accepted in every cycle.
module display_idle_fade_controller
  import difc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [WORD_W-1:0]    in_now_ms,
  input  logic                 in_usb_power,
  input  logic                 in_enable,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_brightness_write,
  output logic [LEVEL_W-1:0]   out_brightness,
  output logic                 out_wake_consumed,
  output logic                 out_asleep,
  output logic [1:0]           out_mode,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [WORD_W-1:0]  idle_timeout_r;
  logic [SHORT_W-1:0] fade_step_r, fade_out_r, fade_in_r;
  logic               sleep_chg_r;
  logic [LEVEL_W-1:0] user_bright_r, fallback_r;

  // Controller state.
  ctl_state_t         state_r, state_nxt;
  mode_t              mode_r;
  logic [WORD_W-1:0]  last_act_r, fade_start_r, fade_last_r;
  logic [LEVEL_W-1:0] fade_origin_r, fade_target_r;
  logic               fast_sleep_r;

  // The item being worked on and its partial result.
  logic [KIND_W-1:0]  item_kind_r;
  logic [WORD_W-1:0]  item_now_r;
  logic               item_usb_r, item_en_r;
  logic               res_wr_r, res_consumed_r;
  logic [LEVEL_W-1:0] res_level_r;

  // Result register.
  logic               out_valid_r, out_wr_r, out_consumed_r, out_asleep_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [1:0]         out_mode_r;

  logic [DIGIT_CNT_W-1:0] cnt_r;

  logic               in_fire, out_free;
  logic               lane_load, lane_step, md_start;
  logic [LEVEL_W-1:0] awake_level;
  logic               fading, sleepy, usb_keeps_awake;
  logic [WORD_W-1:0]  timeout, step_thr, dur_thr;
  logic [SHORT_W-1:0] dur;
  logic               ge_idle, ge_step, ge_dur;
  logic [WORD_W-1:0]  diff_idle, diff_step, elapsed;
  logic               span_neg;
  logic [LEVEL_W-1:0] span_mag, quo;
  logic               md_done;
  logic [LEVEL_W+1:0] level_sum;
  logic [LEVEL_W-1:0] level_clamped;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;

  assign awake_level     = (user_bright_r != '0) ? user_bright_r : fallback_r;
  assign fading          = (mode_r == MODE_FADE_OUT) || (mode_r == MODE_FADE_IN);
  assign sleepy          = (mode_r == MODE_FADE_OUT) || (mode_r == MODE_ASLEEP);
  assign usb_keeps_awake = ~fast_sleep_r & ~sleep_chg_r & item_usb_r;

  // Thresholds follow the mode left by the wake-up check of the same tick.
  assign timeout  = fast_sleep_r ? FAST_TIMEOUT_MS : idle_timeout_r;
  assign dur      = (mode_r == MODE_FADE_OUT) ? fade_out_r : fade_in_r;
  assign step_thr = WORD_W'(fade_step_r);
  assign dur_thr  = WORD_W'(dur);

  // Three lanes walk the timestamps together, four bits per cycle.
  difc_sub_lane u_lane_idle (
    .clk    (clk),
    .load_i (lane_load),
    .step_i (lane_step),
    .min_i  (item_now_r),
    .sub_i  (last_act_r),
    .thr_i  (timeout),
    .ge_o   (ge_idle),
    .diff_o (diff_idle)
  );

  difc_sub_lane u_lane_step (
    .clk    (clk),
    .load_i (lane_load),
    .step_i (lane_step),
    .min_i  (item_now_r),
    .sub_i  (fade_last_r),
    .thr_i  (step_thr),
    .ge_o   (ge_step),
    .diff_o (diff_step)
  );

  difc_sub_lane u_lane_dur (
    .clk    (clk),
    .load_i (lane_load),
    .step_i (lane_step),
    .min_i  (item_now_r),
    .sub_i  (fade_start_r),
    .thr_i  (dur_thr),
    .ge_o   (ge_dur),
    .diff_o (elapsed)
  );

  // The interpolation works on magnitudes; the sign is put back afterwards,
  // which gives truncation toward zero.
  assign span_neg = (fade_target_r < fade_origin_r);
  assign span_mag = span_neg ? (fade_origin_r - fade_target_r)
                             : (fade_target_r - fade_origin_r);

  difc_muldiv u_muldiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (md_start),
    .mag_i     (span_mag),
    .elapsed_i (elapsed[SHORT_W-1:0]),
    .dur_i     (dur),
    .done_o    (md_done),
    .quo_o     (quo)
  );

  always_comb begin
    if (span_neg) begin
      level_sum = {2'b00, fade_origin_r} - {2'b00, quo};
    end else begin
      level_sum = {2'b00, fade_origin_r} + {2'b00, quo};
    end
    if (level_sum[LEVEL_W+1]) begin
      level_clamped = '0;
    end else if (level_sum[LEVEL_W]) begin
      level_clamped = BRIGHT_MAX;
    end else begin
      level_clamped = level_sum[LEVEL_W-1:0];
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = (item_kind_r == KIND_TICK) ? ST_LOAD : ST_DONE;
      ST_LOAD: state_nxt = ST_CMP;
      ST_CMP:  if (cnt_r == DIGIT_CNT_W'(DIGITS - 1)) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (fading && ge_step && !ge_dur) ? ST_DIV : ST_DONE;
      ST_DIV:  if (md_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready  = 1'b0;
    lane_load = 1'b0;
    lane_step = 1'b0;
    md_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_PREP: ;
      ST_LOAD: lane_load = 1'b1;
      ST_CMP:  lane_step = 1'b1;
      ST_EVAL: md_start  = fading & ge_step & ~ge_dur;
      ST_DIV:  ;
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (lane_step) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // Latch the accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_kind_r <= in_kind;
      item_now_r  <= in_now_ms;
      item_usb_r  <= in_usb_power;
      item_en_r   <= in_enable;
    end
  end

  // Architectural state, configuration and the partial result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= WORD_W'(60000);
      fade_step_r    <= SHORT_W'(20);
      fade_out_r     <= SHORT_W'(1000);
      fade_in_r      <= SHORT_W'(300);
      sleep_chg_r    <= 1'b0;
      user_bright_r  <= LEVEL_W'(160);
      fallback_r     <= LEVEL_W'(200);
      mode_r         <= MODE_AWAKE;
      last_act_r     <= '0;
      fade_start_r   <= '0;
      fade_last_r    <= '0;
      fade_origin_r  <= LEVEL_W'(200);
      fade_target_r  <= '0;
      fast_sleep_r   <= 1'b0;
      res_wr_r       <= 1'b0;
      res_level_r    <= '0;
      res_consumed_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
          REG_FADE_STEP:    fade_step_r    <= cfg_data[SHORT_W-1:0];
          REG_FADE_OUT:     fade_out_r     <= cfg_data[SHORT_W-1:0];
          REG_FADE_IN:      fade_in_r      <= cfg_data[SHORT_W-1:0];
          REG_SLEEP_CHG:    sleep_chg_r    <= cfg_data[0];
          REG_USER_BRIGHT:  user_bright_r  <= cfg_data[LEVEL_W-1:0];
          REG_FALLBACK:     fallback_r     <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            res_wr_r       <= 1'b0;
            res_level_r    <= '0;
            res_consumed_r <= 1'b0;
          end
        end
        ST_PREP: begin
          // Waking on a tick, activity or wake item fades in from black to the awake level.
          case (item_kind_r) inside
            KIND_TICK: begin
              if (usb_keeps_awake) begin
                last_act_r <= item_now_r;
                if (sleepy) begin
                  fade_origin_r <= '0;
                  fade_target_r <= awake_level;
                  fade_start_r  <= item_now_r;
                  fade_last_r   <= item_now_r;
                  mode_r        <= MODE_FADE_IN;
                end
              end
            end
            KIND_ACTIVITY, KIND_WAKE: begin
              last_act_r <= item_now_r;
              if (sleepy) begin
                fade_origin_r <= '0;
                fade_target_r <= awake_level;
                fade_start_r  <= item_now_r;
                fade_last_r   <= item_now_r;
                mode_r        <= MODE_FADE_IN;
              end
              // A wake press is swallowed when it wakes the panel or one is
              // already on its way up.
              if (item_kind_r == KIND_WAKE && (sleepy || mode_r == MODE_FADE_IN)) begin
                res_consumed_r <= 1'b1;
              end
            end
            KIND_FAST: begin
              if (item_en_r != fast_sleep_r) begin
                fast_sleep_r <= item_en_r;
                last_act_r   <= item_now_r;
              end
            end
            KIND_INIT: begin
              mode_r      <= MODE_AWAKE;
              last_act_r  <= item_now_r;
              res_wr_r    <= 1'b1;
              res_level_r <= awake_level;
            end
            default: ;
          endcase
        end
        ST_EVAL: begin
          if (mode_r == MODE_AWAKE) begin
            if (ge_idle) begin
              fade_origin_r <= awake_level;
              fade_target_r <= '0;
              fade_start_r  <= item_now_r;
              fade_last_r   <= item_now_r;
              mode_r        <= MODE_FADE_OUT;
            end
          end else if (fading && ge_step) begin
            fade_last_r <= item_now_r;
            res_wr_r    <= 1'b1;
            // Once the duration has run out the fade lands on its target.
            if (ge_dur) begin
              res_level_r <= fade_target_r;
              mode_r      <= (mode_r == MODE_FADE_OUT) ? MODE_ASLEEP : MODE_AWAKE;
            end
          end
        end
        ST_DIV: begin
          if (md_done) begin
            res_level_r <= level_clamped;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register; loaded as the sequencer leaves its final state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_wr_r       <= res_wr_r;
      out_level_r    <= res_level_r;
      out_consumed_r <= res_consumed_r;
      out_asleep_r   <= sleepy;
      out_mode_r     <= mode_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_brightness_write = out_wr_r;
  assign out_brightness       = out_level_r;
  assign out_wake_consumed    = out_consumed_r;
  assign out_asleep           = out_asleep_r;
  assign out_mode             = out_mode_r;

endmodule

// File: src/difc_sub_lane.sv
// Digit-serial lane: forms a wrapping difference and compares it with a threshold.
module difc_sub_lane
  import difc_pkg::*;
(
  input  logic              clk,
  input  logic              load_i,
  input  logic              step_i,
  input  logic [WORD_W-1:0] min_i,
  input  logic [WORD_W-1:0] sub_i,
  input  logic [WORD_W-1:0] thr_i,
  output logic              ge_o,
  output logic [WORD_W-1:0] diff_o
);

  logic [WORD_W-1:0] min_r, sub_r, thr_r, diff_r;
  logic              bd_r, bc_r;
  logic [DIGIT_W:0]  dsum, csum;

  // Two chained digit subtractors: the difference digit feeds the compare.
  always_comb begin
    dsum = {1'b0, min_r[DIGIT_W-1:0]} - {1'b0, sub_r[DIGIT_W-1:0]} - (DIGIT_W+1)'(bd_r);
    csum = {1'b0, dsum[DIGIT_W-1:0]} - {1'b0, thr_r[DIGIT_W-1:0]} - (DIGIT_W+1)'(bc_r);
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      min_r  <= min_i;
      sub_r  <= sub_i;
      thr_r  <= thr_i;
      bd_r   <= 1'b0;
      bc_r   <= 1'b0;
    end else if (step_i) begin
      min_r  <= min_r >> DIGIT_W;
      sub_r  <= sub_r >> DIGIT_W;
      thr_r  <= thr_r >> DIGIT_W;
      diff_r <= {dsum[DIGIT_W-1:0], diff_r[WORD_W-1:DIGIT_W]};
      bd_r   <= dsum[DIGIT_W];
      bc_r   <= csum[DIGIT_W];
    end
  end

  // A final borrow out of the compare means the difference is below the threshold.
  assign ge_o   = ~bc_r;
  assign diff_o = diff_r;

endmodule

// File: src/difc_muldiv.sv
// Shift-add multiplier followed by a restoring divider for the fade interpolation.
module difc_muldiv
  import difc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic [LEVEL_W-1:0] mag_i,
  input  logic [SHORT_W-1:0] elapsed_i,
  input  logic [SHORT_W-1:0] dur_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] quo_o
);

  md_phase_t            phase_r, phase_nxt;
  logic [MD_CNT_W-1:0]  cnt_r;
  logic [LEVEL_W-1:0]   mag_r, quo_r;
  logic [PROD_W-1:0]    acc_r, mcand_r, dvs_r;
  logic                 done_r;
  logic                 mul_en, div_en, last_step;

  assign last_step = (cnt_r == MD_CNT_W'(MD_STEPS - 1));

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      MD_IDLE: if (start_i) phase_nxt = MD_MUL;
      MD_MUL:  if (last_step) phase_nxt = MD_DIV;
      MD_DIV:  if (last_step) phase_nxt = MD_IDLE;
      default: phase_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    div_en = 1'b0;
    unique case (phase_r)
      MD_IDLE: ;
      MD_MUL:  mul_en = 1'b1;
      MD_DIV:  div_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= div_en & last_step;
      if (mul_en || div_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == MD_IDLE && start_i) begin
      mag_r   <= mag_i;
      acc_r   <= '0;
      mcand_r <= PROD_W'(elapsed_i);
      dvs_r   <= {1'b0, dur_i, {(LEVEL_W-1){1'b0}}};
      quo_r   <= '0;
    end else if (mul_en) begin
      if (mag_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= mcand_r << 1;
      mag_r   <= mag_r >> 1;
    end else if (div_en) begin
      if (acc_r >= dvs_r) begin
        acc_r <= acc_r - dvs_r;
        quo_r <= {quo_r[LEVEL_W-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[LEVEL_W-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

// File: src/difc_checker.sv
// Port-level checker for the display idle fade controller, bound to the top level.
module difc_checker
  import difc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_brightness_write,
  input logic [LEVEL_W-1:0]   out_brightness,
  input logic                 out_wake_consumed,
  input logic                 out_asleep,
  input logic [1:0]           out_mode
);

  // A stalled result beat holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_brightness)
      && $stable(out_mode) && $stable(out_brightness_write))
    else $error("result beat changed while stalled");

  // The asleep flag follows the reported mode.
  a_asleep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_asleep == (out_mode == MODE_FADE_OUT || out_mode == MODE_ASLEEP))
    else $error("asleep flag disagrees with mode");

  // No write means a zero level.
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_brightness_write |-> out_brightness == '0)
    else $error("brightness reported without a write");

  // A swallowed wake press always leaves the panel fading in.
  a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_consumed |-> out_mode == MODE_FADE_IN)
    else $error("wake press swallowed outside a fade-in");

  // Nothing is offered in the first cycle out of reset.
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind display_idle_fade_controller difc_checker u_difc_checker (.*);
